/* hw/rtl/cdn_pkg.sv */
// ============================================================================
// cdn_pkg
// Shared types, codes and calendar helpers for the calendar date normalizer.
// ============================================================================
package cdn_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTHS   = 12;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Month lengths for a common year, January first.
    localparam logic [4:0] MONTH_LEN [MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        MODE_NORM       = 3'd0,
        MODE_NEXT_MONTH = 3'd1,
        MODE_PREV_MONTH = 3'd2,
        MODE_NEXT_YEAR  = 3'd3,
        MODE_PREV_YEAR  = 3'd4,
        MODE_FIRST      = 3'd5,
        MODE_LAST       = 3'd6,
        MODE_RSVD       = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_CLAMP,
        ST_CARRY_S,
        ST_CARRY_M,
        ST_CARRY_H,
        ST_FOLD,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_STEP,
        OP_CLAMP,
        OP_CARRY_S,
        OP_CARRY_M,
        OP_CARRY_H,
        OP_FOLD,
        OP_WALK
    } op_t;

    typedef struct packed {
        logic  load;
        op_t   op;
        logic  done;
    } cmd_t;

    typedef struct packed {
        logic  bad;
        mode_t mode;
        logic  walk_more;
    } status_t;

    // Gregorian leap rule. Divisibility by 25 uses a reciprocal multiply that
    // is exact over the whole 14-bit year range.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        logic [9:0]  q;
        logic        div25;
        prod  = 27'(y) * 27'd5243;
        q     = prod[26:17];
        div25 = ((14'(q) * 14'd25) == y);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m,
                                           input logic [YEAR_W-1:0] y);
        logic [3:0] idx;
        logic [4:0] d;
        idx = ((m >= MONTH_JAN) && (m <= MONTH_DEC)) ? (m - 4'd1) : 4'd0;
        d   = MONTH_LEN[idx];
        if ((m == MONTH_FEB) && is_leap(y))
        begin
            d = d + 5'd1;
        end
        return d;
    endfunction

endpackage

/* hw/rtl/calendar_date_normalizer.sv */
// ============================================================================
// calendar_date_normalizer
// Gregorian date and time normalizer and calendar stepper, one word at a time.
// ============================================================================
// Flow: first and last of month and rejected words go from the step straight
// to done; the normalize and year step modes then run the carry steps, the
// fold and the month walk, and the month step modes add a day clamp before
// them. The month walk subtracts one month length per cycle while the day is
// beyond its month. A new word is taken only in idle, after done.
// Reset returns the sequencer to idle; the datapath registers are not reset.
// The receiver cannot stall: done is high for exactly one cycle per word.
// ============================================================================
module calendar_date_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [13:0] year_in,
    input  logic [7:0]  month_in,
    input  logic [7:0]  day_in,
    input  logic [7:0]  hour_in,
    input  logic [7:0]  minute_in,
    input  logic [7:0]  second_in,
    output logic        done,
    output logic [13:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out,
    output logic        bad_input
);

    // The sequencer issues one operation per cycle to the datapath: a mode
    // step (month or year step, first or last of month, and the range check),
    // an optional day clamp, three carry steps for seconds, minutes and hours,
    // the month fold, and then the month walk, which repeats while the day is
    // beyond the length of its month.
    cdn_pkg::cmd_t    cmd;
    cdn_pkg::status_t status;

    cdn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // The datapath holds the word being worked on. Its registers drive the
    // result ports directly, so the result is valid during the cycle that the
    // done strobe marks. A rejected word shows zeros with bad_input set.
    cdn_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .mode       (mode),
        .year_in    (year_in),
        .month_in   (month_in),
        .day_in     (day_in),
        .hour_in    (hour_in),
        .minute_in  (minute_in),
        .second_in  (second_in),
        .status     (status),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .hour_out   (hour_out),
        .minute_out (minute_out),
        .second_out (second_out),
        .bad_input  (bad_input)
    );

    assign done = cmd.done;

endmodule

/* hw/rtl/cdn_ctrl.sv */
// ============================================================================
// cdn_ctrl
// Sequencer that walks one word through step, carry, fold and month walk.
// ============================================================================
module cdn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cdn_pkg::status_t status,
    output logic             busy,
    output cdn_pkg::cmd_t    cmd
);

    cdn_pkg::state_t state_reg;
    cdn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cdn_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = cdn_pkg::ST_STEP;
                end
            end
            cdn_pkg::ST_STEP:
            begin
                if (status.bad)
                begin
                    state_next = cdn_pkg::ST_DONE;
                end
                else
                begin
                    unique case (status.mode)
                        cdn_pkg::MODE_NORM,
                        cdn_pkg::MODE_NEXT_YEAR,
                        cdn_pkg::MODE_PREV_YEAR:  state_next = cdn_pkg::ST_CARRY_S;
                        cdn_pkg::MODE_NEXT_MONTH,
                        cdn_pkg::MODE_PREV_MONTH: state_next = cdn_pkg::ST_CLAMP;
                        default:                  state_next = cdn_pkg::ST_DONE;
                    endcase
                end
            end
            cdn_pkg::ST_CLAMP:   state_next = cdn_pkg::ST_CARRY_S;
            cdn_pkg::ST_CARRY_S: state_next = cdn_pkg::ST_CARRY_M;
            cdn_pkg::ST_CARRY_M: state_next = cdn_pkg::ST_CARRY_H;
            cdn_pkg::ST_CARRY_H: state_next = cdn_pkg::ST_FOLD;
            cdn_pkg::ST_FOLD:    state_next = cdn_pkg::ST_WALK;
            cdn_pkg::ST_WALK:
            begin
                if (!status.walk_more)
                begin
                    state_next = cdn_pkg::ST_DONE;
                end
            end
            cdn_pkg::ST_DONE:    state_next = cdn_pkg::ST_IDLE;
            default:             state_next = cdn_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != cdn_pkg::ST_IDLE);
        cmd.load = (state_reg == cdn_pkg::ST_IDLE) && start;
        cmd.done = (state_reg == cdn_pkg::ST_DONE);
        unique case (state_reg)
            cdn_pkg::ST_STEP:    cmd.op = cdn_pkg::OP_STEP;
            cdn_pkg::ST_CLAMP:   cmd.op = cdn_pkg::OP_CLAMP;
            cdn_pkg::ST_CARRY_S: cmd.op = cdn_pkg::OP_CARRY_S;
            cdn_pkg::ST_CARRY_M: cmd.op = cdn_pkg::OP_CARRY_M;
            cdn_pkg::ST_CARRY_H: cmd.op = cdn_pkg::OP_CARRY_H;
            cdn_pkg::ST_FOLD:    cmd.op = cdn_pkg::OP_FOLD;
            cdn_pkg::ST_WALK:    cmd.op = cdn_pkg::OP_WALK;
            default:             cmd.op = cdn_pkg::OP_NONE;
        endcase
    end

endmodule

/* hw/rtl/cdn_datapath.sv */
// ============================================================================
// cdn_datapath
// Working registers for one date word and the arithmetic for each step.
// ============================================================================
module cdn_datapath (
    input  logic                        clk,
    input  cdn_pkg::cmd_t               cmd,
    input  logic [2:0]                  mode,
    input  logic [cdn_pkg::YEAR_W-1:0]  year_in,
    input  logic [7:0]                  month_in,
    input  logic [7:0]                  day_in,
    input  logic [7:0]                  hour_in,
    input  logic [7:0]                  minute_in,
    input  logic [7:0]                  second_in,
    output cdn_pkg::status_t            status,
    output logic [cdn_pkg::YEAR_W-1:0]  year_out,
    output logic [3:0]                  month_out,
    output logic [4:0]                  day_out,
    output logic [4:0]                  hour_out,
    output logic [5:0]                  minute_out,
    output logic [5:0]                  second_out,
    output logic                        bad_input
);

    // Quotient by 60 of a value below 300.
    function automatic logic [2:0] div60(input logic [8:0] v);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= 4; k++)
        begin
            if (v >= 9'(60 * k))
            begin
                q = 3'(k);
            end
        end
        return q;
    endfunction

    // Quotient by 24 of a value below 264.
    function automatic logic [3:0] div24(input logic [8:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k <= 10; k++)
        begin
            if (v >= 9'(24 * k))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    cdn_pkg::mode_t              mode_reg,   mode_next;
    logic [cdn_pkg::YEAR_W-1:0]  year_reg,   year_next;
    logic [7:0]                  month_reg,  month_next;
    logic [8:0]                  day_reg,    day_next;
    logic [8:0]                  hour_reg,   hour_next;
    logic [8:0]                  minute_reg, minute_next;
    logic [7:0]                  second_reg, second_next;
    logic                        bad_reg,    bad_next;

    logic [4:0]  dim;
    logic        walk_more;
    logic        bad_now;
    logic [2:0]  q60_s;
    logic [2:0]  q60_m;
    logic [3:0]  q24;
    logic [7:0]  m1;
    logic [12:0] fold_prod;
    logic [5:0]  fold_q;
    logic [7:0]  fold_rem;

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        bad_reg    <= bad_next;
    end

    always_comb
    begin
        dim       = cdn_pkg::days_in(month_reg[3:0], year_reg);
        walk_more = (day_reg > 9'(dim));
        bad_now   = (mode_reg != cdn_pkg::MODE_NORM) &&
                    ((mode_reg == cdn_pkg::MODE_RSVD) ||
                     (month_reg < 8'(cdn_pkg::MONTH_JAN)) ||
                     (month_reg > 8'(cdn_pkg::MONTH_DEC)));
        q60_s     = div60({1'b0, second_reg});
        q60_m     = div60(minute_reg);
        q24       = div24(hour_reg);
        // (month - 1) / 12 taken as ((month - 1) / 4) / 3 with a reciprocal.
        m1        = month_reg - 8'd1;
        fold_prod = 13'(m1[7:2]) * 13'd43;
        fold_q    = fold_prod[12:7];
        fold_rem  = m1 - 8'(fold_q) * 8'd12;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        bad_next    = bad_reg;

        if (cmd.load)
        begin
            mode_next   = cdn_pkg::mode_t'(mode);
            year_next   = year_in;
            month_next  = month_in;
            day_next    = {1'b0, day_in};
            hour_next   = {1'b0, hour_in};
            minute_next = {1'b0, minute_in};
            second_next = second_in;
            bad_next    = 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                cdn_pkg::OP_STEP:
                begin
                    bad_next = bad_now;
                    unique case (mode_reg)
                        cdn_pkg::MODE_NEXT_MONTH:
                        begin
                            if (month_reg < 8'(cdn_pkg::MONTH_DEC))
                            begin
                                month_next = month_reg + 8'd1;
                            end
                            else
                            begin
                                month_next = 8'(cdn_pkg::MONTH_JAN);
                                year_next  = year_reg + 14'd1;
                            end
                        end
                        cdn_pkg::MODE_PREV_MONTH:
                        begin
                            if (month_reg > 8'(cdn_pkg::MONTH_JAN))
                            begin
                                month_next = month_reg - 8'd1;
                            end
                            else
                            begin
                                month_next = 8'(cdn_pkg::MONTH_DEC);
                                year_next  = year_reg - 14'd1;
                            end
                        end
                        cdn_pkg::MODE_NEXT_YEAR: year_next = year_reg + 14'd1;
                        cdn_pkg::MODE_PREV_YEAR: year_next = year_reg - 14'd1;
                        cdn_pkg::MODE_FIRST,
                        cdn_pkg::MODE_LAST:
                        begin
                            day_next    = (mode_reg == cdn_pkg::MODE_FIRST) ?
                                          9'd1 : 9'(dim);
                            hour_next   = 9'd0;
                            minute_next = 9'd0;
                            second_next = 8'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                cdn_pkg::OP_CLAMP:
                begin
                    if (walk_more)
                    begin
                        day_next = 9'(dim);
                    end
                end
                cdn_pkg::OP_CARRY_S:
                begin
                    second_next = 8'({1'b0, second_reg} - 9'(q60_s) * 9'd60);
                    minute_next = minute_reg + 9'(q60_s);
                end
                cdn_pkg::OP_CARRY_M:
                begin
                    minute_next = minute_reg - 9'(q60_m) * 9'd60;
                    hour_next   = hour_reg + 9'(q60_m);
                end
                cdn_pkg::OP_CARRY_H:
                begin
                    hour_next = hour_reg - 9'(q24) * 9'd24;
                    day_next  = day_reg + 9'(q24);
                end
                cdn_pkg::OP_FOLD:
                begin
                    if (month_reg == 8'd0)
                    begin
                        year_next  = year_reg - 14'd1;
                        month_next = 8'(cdn_pkg::MONTH_DEC);
                    end
                    else
                    begin
                        year_next  = year_reg + 14'(fold_q);
                        month_next = fold_rem + 8'd1;
                    end
                end
                cdn_pkg::OP_WALK:
                begin
                    if (walk_more)
                    begin
                        day_next = day_reg - 9'(dim);
                        if (month_reg < 8'(cdn_pkg::MONTH_DEC))
                        begin
                            month_next = month_reg + 8'd1;
                        end
                        else
                        begin
                            month_next = 8'(cdn_pkg::MONTH_JAN);
                            year_next  = year_reg + 14'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        status.bad       = bad_now;
        status.mode      = mode_reg;
        status.walk_more = walk_more;

        bad_input  = bad_reg;
        year_out   = bad_reg ? '0 : year_reg;
        month_out  = bad_reg ? '0 : month_reg[3:0];
        day_out    = bad_reg ? '0 : day_reg[4:0];
        hour_out   = bad_reg ? '0 : hour_reg[4:0];
        minute_out = bad_reg ? '0 : minute_reg[5:0];
        second_out = bad_reg ? '0 : second_reg[5:0];
    end

endmodule
